FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker in rsig_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define RSIG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define RSIG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/rsig_pkg.sv
package rsig_pkg;

    localparam int MAX_GROUP = 16;
    localparam int DATA_W    = 32;
    localparam int GSIZE_W   = 5;
    // Wide enough for a group count at the largest group size that i_group_size can carry (31).
    localparam int CNT_W     = 7;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] cnt;
        logic             rev;
        logic             last;
    } t_job;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [CNT_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic en;
        logic bank;
    } t_rel;

endpackage

FILE: hw/rtl/rsig_in_if.sv
interface rsig_in_if;
    import rsig_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] element_value;
    logic                     list_end;

    modport source (output valid, output element_value, output list_end, input ready);
    modport sink   (input valid, input element_value, input list_end, output ready);
endinterface

FILE: hw/rtl/rsig_out_if.sv
interface rsig_out_if;
    import rsig_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_value;
    logic                     run_last;
    logic                     out_list_end;

    modport source (output valid, output out_value, output run_last, output out_list_end,
                    input ready);
    modport sink   (input valid, input out_value, input run_last, input out_list_end,
                    output ready);
endinterface

FILE: hw/rtl/rsig_front.sv
module rsig_front #(
    parameter int MaxGroup = rsig_pkg::MAX_GROUP
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rsig_pkg::GSIZE_W-1:0] i_group_size,
    rsig_in_if.sink                      i_in,
    input  logic                         i_job_full,
    input  rsig_pkg::t_rel               i_rel,
    output rsig_pkg::t_wr                o_wr,
    output logic                         o_job_push,
    output rsig_pkg::t_job               o_job
);
    import rsig_pkg::*;

    localparam int CntW = $clog2(MaxGroup + 1);
    localparam int CmpW = (CntW > GSIZE_W) ? CntW : GSIZE_W;

    logic [CntW-1:0] r_fill;
    logic            r_bank;
    logic [1:0]      r_busy;

    logic [CmpW-1:0] gs_x;
    logic [CmpW-1:0] max_x;
    logic [CmpW-1:0] k_eff;
    logic [CmpW-1:0] n_x;
    logic            accept;
    logic            full_group;
    logic            close;

    always_comb begin
        gs_x  = CmpW'(i_group_size);
        max_x = CmpW'(MaxGroup);
        if (gs_x > max_x) begin
            k_eff = max_x;
        end else if (gs_x == '0) begin
            k_eff = CmpW'(1);
        end else begin
            k_eff = gs_x;
        end
        n_x        = CmpW'(r_fill) + CmpW'(1);
        full_group = (n_x >= k_eff);
    end

    assign i_in.ready = !r_busy[r_bank] && !i_job_full;
    assign accept     = i_in.valid && i_in.ready;
    assign close      = accept && (full_group || i_in.list_end);

    assign o_wr.en   = accept;
    assign o_wr.bank = r_bank;
    assign o_wr.idx  = CNT_W'(r_fill);
    assign o_wr.data = i_in.element_value;

    assign o_job_push = close;
    assign o_job.bank = r_bank;
    assign o_job.cnt  = CNT_W'(n_x);
    assign o_job.rev  = full_group;
    assign o_job.last = i_in.list_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            for (int b = 0; b < 2; b++) begin
                if (i_rel.en && (i_rel.bank == 1'(b))) begin
                    r_busy[b] <= 1'b0;
                end
                if (close && (r_bank == 1'(b))) begin
                    r_busy[b] <= 1'b1;
                end
            end
            if (close) begin
                r_fill <= '0;
                r_bank <= !r_bank;
            end else if (accept) begin
                r_fill <= n_x[CntW-1:0];
            end
        end
    end

endmodule

FILE: hw/rtl/rsig_jobq.sv
module rsig_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rsig_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rsig_pkg::t_job o_job
);
    import rsig_pkg::*;

    t_job       r_mem [2];
    logic       r_rp;
    logic       r_wp;
    logic [1:0] r_occ;

    assign o_full  = (r_occ == 2'd2);
    assign o_valid = (r_occ != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
            r_occ <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_occ <= r_occ + 2'd1;
            end else if (i_pop && !i_push) begin
                r_occ <= r_occ - 2'd1;
            end
        end
    end

endmodule

FILE: hw/rtl/rsig_back.sv
module rsig_back #(
    parameter int MaxGroup = rsig_pkg::MAX_GROUP
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rsig_pkg::t_wr  i_wr,
    input  logic           i_job_valid,
    input  rsig_pkg::t_job i_job,
    output logic           o_job_pop,
    output rsig_pkg::t_rel o_rel,
    rsig_out_if.source     o_out
);
    import rsig_pkg::*;

    localparam int CntW  = $clog2(MaxGroup + 1);
    localparam int IdxW  = (MaxGroup > 1) ? $clog2(MaxGroup) : 1;
    localparam int Depth = 2 ** (IdxW + 1);

    logic [DATA_W-1:0] r_mem [Depth];

    logic            r_act;
    t_job            r_job;
    logic [CntW-1:0] r_idx;

    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic              r_rd_run;
    logic              r_rd_end;

    logic [DATA_W-1:0] r_ob_val [2];
    logic              r_ob_run [2];
    logic              r_ob_end [2];
    logic [1:0]        r_ob_occ;
    logic              r_ob_rp;
    logic              r_ob_wp;

    logic            ob_pop;
    logic            issue;
    logic            last_issue;
    logic [CntW-1:0] cnt_m1;
    logic [CntW-1:0] sel;
    logic [IdxW:0]   rd_addr;
    logic            load;

    assign ob_pop     = o_out.valid && o_out.ready;
    assign issue      = r_act && (((3'(r_ob_occ) + 3'(r_rd_vld)) <= 3'd1) || ob_pop);
    assign cnt_m1     = CntW'(r_job.cnt - CNT_W'(1));
    assign last_issue = (r_idx == cnt_m1);
    assign sel        = r_job.rev ? (cnt_m1 - r_idx) : r_idx;
    assign rd_addr    = {r_job.bank, sel[IdxW-1:0]};
    assign load       = i_job_valid && (!r_act || (issue && last_issue));

    assign o_job_pop  = load;
    assign o_rel.en   = issue && last_issue;
    assign o_rel.bank = r_job.bank;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[IdxW-1:0]}] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_run  <= last_issue;
            r_rd_end  <= last_issue && r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (load) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (issue && last_issue) begin
                r_act <= 1'b0;
            end else if (issue) begin
                r_idx <= r_idx + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

    assign o_out.valid        = (r_ob_occ != 2'd0);
    assign o_out.out_value    = r_ob_val[r_ob_rp];
    assign o_out.run_last     = r_ob_run[r_ob_rp];
    assign o_out.out_list_end = r_ob_end[r_ob_rp];

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_ob_val[r_ob_wp] <= r_rd_data;
            r_ob_run[r_ob_wp] <= r_rd_run;
            r_ob_end[r_ob_wp] <= r_rd_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_occ <= '0;
            r_ob_rp  <= 1'b0;
            r_ob_wp  <= 1'b0;
        end else begin
            if (r_rd_vld) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= !r_ob_rp;
            end
            if (r_rd_vld && !ob_pop) begin
                r_ob_occ <= r_ob_occ + 2'd1;
            end else if (ob_pop && !r_rd_vld) begin
                r_ob_occ <= r_ob_occ - 2'd1;
            end
        end
    end

endmodule

FILE: hw/rtl/reverse_stream_in_groups.sv
// Channel  | Dir | Payload                                | Beat taken when
// i_in     | in  | element_value, list_end                | valid && ready
// o_out    | out | out_value, run_last, out_list_end      | valid && ready
// cfg      | in  | i_cfg_data (group size)                | i_cfg_we
//
// Beats are written into one of two group banks while the other drains. Every second
// bank turnaround idles the input until the drained bank is released, and each group
// leaves at one beat per cycle while the output is taken, its first result passing the
// job queue, the bank read register and the output buffer after the closing beat.
// Reset is synchronous and clears the fill count, the bank flags and both queues; the
// bank contents are not cleared. A stalled output fills the two-entry output buffer,
// then holds the banks, then drops input ready.
module reverse_stream_in_groups #(
    parameter int MaxGroup = rsig_pkg::MAX_GROUP
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rsig_pkg::GSIZE_W-1:0] i_cfg_data,
    rsig_in_if.sink                      i_in,
    rsig_out_if.source                   o_out
);
    import rsig_pkg::*;

    logic [GSIZE_W-1:0] r_group_size;

    t_wr  wr;
    t_rel rel;
    t_job push_job;
    t_job head_job;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GSIZE_W'(1);
        end else if (i_cfg_we) begin
            r_group_size <= i_cfg_data;
        end
    end

    rsig_front #(.MaxGroup(MaxGroup)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_group_size (r_group_size),
        .i_in         (i_in),
        .i_job_full   (job_full),
        .i_rel        (rel),
        .o_wr         (wr),
        .o_job_push   (job_push),
        .o_job        (push_job)
    );

    rsig_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (push_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    rsig_back #(.MaxGroup(MaxGroup)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_job_pop   (job_pop),
        .o_rel       (rel),
        .o_out       (o_out)
    );

endmodule

FILE: hw/rtl/rsig_chk.sv
`include "assert_macros.svh"

module rsig_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic        i_out_run_last,
    input logic        i_out_list_end
);

    // A stalled result beat holds its value and flags.
    `RSIG_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_run_last) && $stable(i_out_list_end))

    // The end of the list always closes a run.
    `RSIG_ASSERT(a_end_in_run, i_clk, i_rst_n, i_out_valid && i_out_list_end |-> i_out_run_last)

    // Nothing is offered on the output right after reset.
    `RSIG_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid)

    // A beat taken in the cycle right after reset cannot yet reach the output.
    `RSIG_ASSERT(a_no_early_out, i_clk, i_rst_n,
        $past(!i_rst_n) && i_in_valid && i_in_ready |=> !i_out_valid)

endmodule

bind reverse_stream_in_groups rsig_chk u_rsig_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_value    (o_out.out_value),
    .i_out_run_last (o_out.run_last),
    .i_out_list_end (o_out.out_list_end)
);
